// File: rtl/plc_sle_pkg.sv
// Package for the PLC scan logic engine: command and node codes, state words,
// sequencer states and shared types. No dependencies.
package plc_sle_pkg;

  localparam logic [1:0] CMD_EVAL   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_COMMIT = 2'd2;
  localparam logic [1:0] CMD_WRITE  = 2'd3;

  localparam logic [3:0] NT_AND  = 4'd0;
  localparam logic [3:0] NT_OR   = 4'd1;
  localparam logic [3:0] NT_XOR  = 4'd2;
  localparam logic [3:0] NT_NOT  = 4'd3;
  localparam logic [3:0] NT_EDGE = 4'd4;
  localparam logic [3:0] NT_SR   = 4'd5;
  localparam logic [3:0] NT_RS   = 4'd6;
  localparam logic [3:0] NT_TON  = 4'd7;
  localparam logic [3:0] NT_TOF  = 4'd8;
  localparam logic [3:0] NT_CTU  = 4'd9;
  localparam logic [3:0] NT_CTD  = 4'd10;
  localparam logic [3:0] NT_BTN  = 4'd11;

  localparam logic [14:0] CNT_MAX     = 15'd32767;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LAST, ST_EXEC, ST_COPY, ST_CDRAIN
  } state_t;

  // per-instance state, kept as one memory word
  typedef struct packed {
    logic        edge_m;
    logic        status;
    logic [15:0] elapsed;
    logic [14:0] count;
  } inst_word_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  node_type;
    logic [2:0]  cnt;
    logic        oen;
    logic [14:0] preset;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic [3:0] w;       // working levels of sig_a..sig_d
    logic       w_out;   // working level of out_sig
    logic       live0;   // live level of sig_a
    logic       ok0;     // sig_a in range
  } sig_bits_t;

  typedef struct packed {
    logic        node_out;
    logic [14:0] count_value;
    inst_word_t  inst;
  } exec_res_t;

endpackage

// File: rtl/plc_sle_sigmem.sv
// Working and live signal buffers, one bit wide, each a synchronous RAM
// with one write and one registered read port. Uses nothing else.
module plc_sle_sigmem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          work_we,
  input  logic [AW-1:0] work_waddr,
  input  logic          work_wdata,
  input  logic          live_we,
  input  logic [AW-1:0] live_waddr,
  input  logic          live_wdata,
  input  logic [AW-1:0] raddr,
  output logic          work_rdata,
  output logic          live_rdata
);
  logic work_mem [DEPTH];
  logic live_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    work_rdata <= work_mem[raddr];
    live_rdata <= live_mem[raddr];
  end
endmodule

// File: rtl/plc_sle_instmem.sv
// Instance state RAM: edge bit, timer status, elapsed ticks, counter value.
// Depends on plc_sle_pkg for the word layout.
module plc_sle_instmem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  plc_sle_pkg::inst_word_t wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output plc_sle_pkg::inst_word_t rdata
);
  import plc_sle_pkg::*;

  inst_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/plc_sle_exec.sv
// Node evaluation and timer tick logic: next instance word and result.
// Depends on plc_sle_pkg.
module plc_sle_exec (
  input  plc_sle_pkg::item_t      item,
  input  plc_sle_pkg::sig_bits_t  bits,
  input  plc_sle_pkg::inst_word_t inst,
  output plc_sle_pkg::exec_res_t  res
);
  import plc_sle_pkg::*;

  logic        r;
  logic [2:0]  ones;
  logic        s_b, r_b, rise, act;
  logic [16:0] sum;
  logic [15:0] el_sat, el2;
  logic        st2;
  logic [14:0] cv;
  inst_word_t  nx;

  always_comb begin
    nx     = inst;
    r      = 1'b0;
    cv     = 15'd0;
    ones   = 3'd0;
    s_b    = bits.w[0];
    r_b    = bits.w[1];
    rise   = bits.w[0] & ~inst.edge_m;
    act    = bits.live0;
    sum    = {1'b0, inst.elapsed} + {1'b0, item.value};
    el_sat = sum[16] ? ELAPSED_MAX : sum[15:0];
    el2    = inst.elapsed;
    st2    = inst.status;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < item.cnt) begin
        ones = ones + {2'd0, bits.w[i]};
      end
    end

    if (item.cmd == CMD_TICK) begin
      if (item.value != 16'd0 && bits.ok0 &&
          (item.node_type == NT_TON || item.node_type == NT_TOF)) begin
        if (item.node_type == NT_TON) begin
          if (act) el2 = el_sat;
          if (el2 >= {1'b0, item.preset}) begin
            el2 = 16'd0;
            st2 = 1'b1;
          end
          if (!act && st2) begin
            el2 = 16'd0;
            st2 = 1'b0;
          end
        end else begin
          if (act) el2 = 16'd0;
          else if (inst.status) el2 = el_sat;
          if (el2 >= {1'b0, item.preset}) begin
            el2 = 16'd0;
            st2 = 1'b0;
          end
        end
        nx.elapsed = el2;
        nx.status  = st2;
      end
      r = (item.node_type == NT_TON || item.node_type == NT_TOF) ? nx.status : 1'b0;
    end else begin
      case (item.node_type)
        NT_AND: r = (ones == item.cnt);
        NT_OR:  r = (ones != 3'd0);
        NT_XOR: r = (ones == 3'd1);
        NT_NOT: r = (item.cnt != 3'd0) & ~bits.w[0];
        NT_EDGE: begin
          if (item.cnt != 3'd0) begin
            r = rise;
            nx.edge_m = bits.w[0];
          end
        end
        NT_SR, NT_RS: begin
          if (item.cnt != 3'd0) begin
            if (s_b && !r_b) r = 1'b1;
            else if (!s_b && r_b) r = 1'b0;
            else if (!s_b && !r_b) r = item.oen & bits.w_out;
            else r = (item.node_type == NT_SR);
          end
        end
        NT_TON: begin
          if (item.cnt != 3'd0 && bits.ok0) begin
            r = bits.w[0] & inst.status;
            if (!bits.w[0]) begin
              nx.status  = 1'b0;
              nx.elapsed = 16'd0;
            end
          end
        end
        NT_TOF: begin
          if (item.cnt != 3'd0 && bits.ok0) begin
            if (bits.w[0]) begin
              r = 1'b1;
              nx.status = 1'b1;
            end else if (inst.elapsed >= {1'b0, item.preset}) begin
              r = 1'b0;
              nx.status = 1'b0;
            end else begin
              r = inst.status;
            end
          end
        end
        NT_CTU, NT_CTD: begin
          if (item.cnt >= 3'd2) begin
            cv = inst.count;
            if (item.node_type == NT_CTU) begin
              if (bits.w[1]) cv = 15'd0;
              else if (rise && cv < CNT_MAX) cv = cv + 15'd1;
              r = (cv >= item.preset);
            end else begin
              if (bits.w[1]) cv = item.preset;
              else if (rise && cv != 15'd0) cv = cv - 15'd1;
              r = (cv == 15'd0);
            end
            nx.count  = cv;
            nx.edge_m = bits.w[0];
          end
        end
        NT_BTN:  r = (item.value != 16'd0);
        default: r = 1'b0;
      endcase
    end

    res.node_out    = r;
    res.count_value = cv;
    res.inst        = nx;
  end
endmodule

// File: rtl/plc_sle_top_unused_guard.sv
// Registered result stage: holds one result for a single-cycle strobe.
// Uses no package; its ports are plain logic vectors.
module plc_sle_outreg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  node_out,
  input  logic [14:0]           count_value,
  input  logic                  scan_done,
  output logic                  out_valid,
  output logic                  out_node_out,
  output logic [14:0]           out_count_value,
  output logic                  out_scan_done
);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load;
    end
    if (load) begin
      out_node_out    <= node_out;
      out_count_value <= count_value;
      out_scan_done   <= scan_done;
    end
  end
endmodule

// File: rtl/plc_scan_logic_engine_core.sv
// PLC scan logic engine, top level: command sequencer around the signal
// and instance RAMs. Depends on plc_sle_pkg and all plc_sle_* modules.
//
// Each request gives exactly one result, shown for one cycle with out_valid;
// the receiver cannot stall. After reset the block clears its RAMs with
// busy high. A signal write is done from idle (busy stays low). Evaluate
// and tick requests pass through ST_READ, ST_LAST and ST_EXEC: the single
// read port of the signal RAM fetches sig_a..sig_d and out_sig one per
// cycle, then the node is evaluated and written back. A commit copies the
// working buffer to the live buffer one signal per cycle in ST_COPY, then
// gives its result from ST_CDRAIN.
module plc_scan_logic_engine_core #(
  parameter int SIGNAL_COUNT   = 256,
  parameter int INSTANCE_COUNT = 64,
  parameter int MAX_FANIN      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_node_type,
  input  logic [5:0]  in_instance_req,
  input  logic [2:0]  in_in_count,
  input  logic [7:0]  in_sig_a,
  input  logic [7:0]  in_sig_b,
  input  logic [7:0]  in_sig_c,
  input  logic [7:0]  in_sig_d,
  input  logic [7:0]  in_out_sig,
  input  logic        in_out_enable,
  input  logic [14:0] in_preset,
  input  logic [15:0] in_value,
  output logic        out_valid,
  output logic        out_node_out,
  output logic [14:0] out_count_value,
  output logic        out_scan_done
);
  import plc_sle_pkg::*;

  localparam int SW   = (SIGNAL_COUNT > 1) ? $clog2(SIGNAL_COUNT) : 1;
  localparam int IW   = (INSTANCE_COUNT > 1) ? $clog2(INSTANCE_COUNT) : 1;
  localparam int MAXN = (SIGNAL_COUNT > INSTANCE_COUNT) ? SIGNAL_COUNT : INSTANCE_COUNT;
  localparam int CW   = $clog2(MAXN + 1);
  localparam logic [2:0] FANIN_LIM = (MAX_FANIN > 4) ? 3'd4 : 3'(MAX_FANIN);

  state_t      state_r, state_nxt;
  item_t       item_r;
  logic [7:0]  sig_r [5];
  logic [IW-1:0] inst_r;
  logic [2:0]  ridx_r, ridx_nxt;
  logic        cap_vld_r;
  logic [2:0]  cap_idx_r;
  logic        cap_ok_r;
  logic [4:0]  wbits_r;
  logic        live0_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        cp_pend_r;
  logic [SW-1:0] cp_addr_r;

  logic          accept;
  logic [2:0]    cnt_clamp;
  logic [IW-1:0] inst_in;
  logic [SW-1:0] raddr;
  logic          rd_ok;
  logic          work_rd, live_rd;
  logic          work_we, live_we, work_wd, live_wd;
  logic [SW-1:0] work_wa, live_wa;
  logic          inst_we;
  logic [IW-1:0] inst_wa;
  inst_word_t    inst_wd, inst_rd;
  sig_bits_t     bits;
  exec_res_t     xres;
  logic          res_load, res_node, res_done;
  logic [14:0]   res_cnt;
  logic          osig_ok;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cnt_clamp = (in_in_count > FANIN_LIM) ? FANIN_LIM : in_in_count;
  assign raddr     = SW'(sig_r[ridx_r]);
  assign rd_ok     = 32'(sig_r[ridx_r]) < SIGNAL_COUNT;
  assign osig_ok   = 32'(state_r == ST_IDLE ? in_out_sig : sig_r[4]) < SIGNAL_COUNT;

  // constant table: request index wrapped to the instance range
  always_comb begin
    inst_in = '0;
    for (int j = 0; j < 64; j++) begin
      if (in_instance_req == 6'(j)) inst_in = IW'(j % INSTANCE_COUNT);
    end
  end

  assign bits.w     = wbits_r[3:0];
  assign bits.w_out = wbits_r[4];
  assign bits.live0 = live0_r;
  assign bits.ok0   = 32'(sig_r[0]) < SIGNAL_COUNT;

  plc_sle_sigmem #(.DEPTH(SIGNAL_COUNT), .AW(SW)) u_sig (
    .clk(clk),
    .work_we(work_we), .work_waddr(work_wa), .work_wdata(work_wd),
    .live_we(live_we), .live_waddr(live_wa), .live_wdata(live_wd),
    .raddr((state_r == ST_COPY) ? cnt_r[SW-1:0] : raddr),
    .work_rdata(work_rd), .live_rdata(live_rd)
  );

  plc_sle_instmem #(.DEPTH(INSTANCE_COUNT), .AW(IW)) u_inst (
    .clk(clk), .we(inst_we), .waddr(inst_wa), .wdata(inst_wd),
    .re(accept), .raddr(inst_in), .rdata(inst_rd)
  );

  plc_sle_exec u_exec (.item(item_r), .bits(bits), .inst(inst_rd), .res(xres));

  plc_sle_outreg u_out (
    .clk(clk), .rst_n(rst_n), .load(res_load),
    .node_out(res_node), .count_value(res_cnt), .scan_done(res_done),
    .out_valid(out_valid), .out_node_out(out_node_out),
    .out_count_value(out_count_value), .out_scan_done(out_scan_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      ridx_r    <= 3'd0;
      cnt_r     <= '0;
      cap_vld_r <= 1'b0;
      cp_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ridx_r    <= ridx_nxt;
      cnt_r     <= cnt_nxt;
      cap_vld_r <= (state_r == ST_READ);
      cp_pend_r <= (state_r == ST_COPY);
    end
    cap_idx_r <= ridx_r;
    cap_ok_r  <= rd_ok;
    cp_addr_r <= cnt_r[SW-1:0];
    if (cap_vld_r) begin
      wbits_r[cap_idx_r] <= cap_ok_r & work_rd;
      if (cap_idx_r == 3'd0) begin
        live0_r <= cap_ok_r & live_rd;
      end
    end
    if (accept) begin
      item_r.cmd       <= in_cmd;
      item_r.node_type <= in_node_type;
      item_r.cnt       <= cnt_clamp;
      item_r.oen       <= in_out_enable;
      item_r.preset    <= in_preset;
      item_r.value     <= in_value;
      sig_r[0]         <= in_sig_a;
      sig_r[1]         <= in_sig_b;
      sig_r[2]         <= in_sig_c;
      sig_r[3]         <= in_sig_d;
      sig_r[4]         <= in_out_sig;
      inst_r           <= inst_in;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ridx_nxt  = ridx_r;
    cnt_nxt   = cnt_r;
    work_we   = 1'b0;
    work_wa   = SW'(in_out_sig);
    work_wd   = (in_value != 16'd0);
    live_we   = 1'b0;
    live_wa   = SW'(in_out_sig);
    live_wd   = (in_value != 16'd0);
    inst_we   = 1'b0;
    inst_wa   = inst_r;
    inst_wd   = xres.inst;
    res_load  = 1'b0;
    res_node  = 1'b0;
    res_cnt   = 15'd0;
    res_done  = 1'b0;

    // a copied bit is written in the cycle after its read
    if (cp_pend_r) begin
      live_we = 1'b1;
      live_wa = cp_addr_r;
      live_wd = work_rd;
    end

    case (state_r)
      ST_CLEAR: begin
        work_wa = cnt_r[SW-1:0];
        live_wa = cnt_r[SW-1:0];
        work_wd = 1'b0;
        live_wd = 1'b0;
        work_we = 32'(cnt_r) < SIGNAL_COUNT;
        live_we = 32'(cnt_r) < SIGNAL_COUNT;
        inst_we = 32'(cnt_r) < INSTANCE_COUNT;
        inst_wa = cnt_r[IW-1:0];
        inst_wd = '0;
        cnt_nxt = cnt_r + CW'(1);
        if (32'(cnt_r) == MAXN - 1) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_WRITE: begin
              work_we  = osig_ok;
              live_we  = osig_ok;
              res_load = 1'b1;
            end
            CMD_COMMIT: begin
              cnt_nxt   = '0;
              state_nxt = ST_COPY;
            end
            default: begin
              ridx_nxt  = 3'd0;
              state_nxt = ST_READ;
            end
          endcase
        end
      end
      ST_READ: begin
        ridx_nxt = ridx_r + 3'd1;
        if (ridx_r == 3'd4) begin
          ridx_nxt  = 3'd0;
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: state_nxt = ST_EXEC;
      ST_EXEC: begin
        inst_we  = 1'b1;
        work_we  = (item_r.cmd == CMD_EVAL) && item_r.oen && osig_ok;
        work_wa  = SW'(sig_r[4]);
        work_wd  = xres.node_out;
        res_load = 1'b1;
        res_node = xres.node_out;
        res_cnt  = xres.count_value;
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        cnt_nxt = cnt_r + CW'(1);
        if (32'(cnt_r) == SIGNAL_COUNT - 1) begin
          cnt_nxt   = '0;
          state_nxt = ST_CDRAIN;
        end
      end
      ST_CDRAIN: begin
        res_load  = 1'b1;
        res_done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: tb/tb_top.sv
// Testbench for plc_scan_logic_engine_core: drives requests and checks every
// result against a behavioral model of the node store. Depends on plc_sle_pkg.
`timescale 1ns / 1ps
module tb_top;
  import plc_sle_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  ntype;
    logic [5:0]  inst;
    logic [2:0]  cnt;
    logic [7:0]  sg [4];
    logic [7:0]  osig;
    logic        oen;
    logic [14:0] preset;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic        node_out;
    logic [14:0] count_value;
    logic        scan_done;
  } node_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = '0;
  logic [3:0] in_node_type = '0;
  logic [5:0] in_instance_req = '0;
  logic [2:0] in_in_count = '0;
  logic [7:0] in_sig_a = '0, in_sig_b = '0, in_sig_c = '0, in_sig_d = '0;
  logic [7:0] in_out_sig = '0;
  logic in_out_enable = 1'b0;
  logic [14:0] in_preset = '0;
  logic [15:0] in_value = '0;
  logic out_valid, out_node_out, out_scan_done;
  logic [14:0] out_count_value;

  plc_scan_logic_engine_core dut (.*);

  always #10 clk = ~clk;

  // model state
  logic        live_sig [256];
  logic        work_sig [256];
  logic        edge_mem [64];
  logic        tmr_on [64];
  logic [15:0] tmr_elapsed [64];
  logic [14:0] ctr_val [64];

  node_res_t expected_q [$];
  int mismatches = 0;
  bit idle_gaps = 1'b1;

  function automatic node_res_t node_predict(req_t r);
    node_res_t o;
    int n, ones;
    int k;
    logic s, rr, c, a, e, ctl, rise, res;
    logic [16:0] el;
    logic [15:0] cv;
    o = '0;
    k = int'(r.inst);
    n = (r.cnt > 4) ? 4 : int'(r.cnt);
    res = 1'b0;
    cv = '0;
    case (r.cmd)
      CMD_TICK: begin
        if (r.value != 0 && (r.ntype == NT_TON || r.ntype == NT_TOF)) begin
          a = live_sig[r.sg[0]];
          el = {1'b0, tmr_elapsed[k]};
          if (r.ntype == NT_TON) begin
            if (a) begin
              el = el + r.value;
              if (el > 17'hFFFF) el = 17'hFFFF;
            end
            if (el >= r.preset) begin
              el = '0;
              tmr_on[k] = 1'b1;
            end
            if (!a && tmr_on[k]) begin
              el = '0;
              tmr_on[k] = 1'b0;
            end
          end else begin
            if (a) el = '0;
            else if (tmr_on[k]) begin
              el = el + r.value;
              if (el > 17'hFFFF) el = 17'hFFFF;
            end
            if (el >= r.preset) begin
              el = '0;
              tmr_on[k] = 1'b0;
            end
          end
          tmr_elapsed[k] = el[15:0];
        end
        o.node_out = (r.ntype == NT_TON || r.ntype == NT_TOF) ? tmr_on[k] : 1'b0;
        return o;
      end
      CMD_COMMIT: begin
        live_sig = work_sig;
        o.scan_done = 1'b1;
        return o;
      end
      CMD_WRITE: begin
        live_sig[r.osig] = (r.value != 0);
        work_sig[r.osig] = (r.value != 0);
        return o;
      end
      default: ;
    endcase
    case (r.ntype)
      NT_AND: begin
        res = 1'b1;
        for (int i = 0; i < n; i++) res = res & work_sig[r.sg[i]];
      end
      NT_OR: for (int i = 0; i < n; i++) res = res | work_sig[r.sg[i]];
      NT_XOR: begin
        ones = 0;
        for (int i = 0; i < n; i++) ones += work_sig[r.sg[i]];
        res = (ones == 1);
      end
      NT_NOT: if (n >= 1) res = !work_sig[r.sg[0]];
      NT_EDGE: if (n >= 1) begin
        c = work_sig[r.sg[0]];
        res = c & !edge_mem[k];
        edge_mem[k] = c;
      end
      NT_SR, NT_RS: if (n >= 1) begin
        s = work_sig[r.sg[0]];
        rr = work_sig[r.sg[1]];
        if (s && !rr) res = 1'b1;
        else if (!s && rr) res = 1'b0;
        else if (!s && !rr) res = r.oen ? work_sig[r.osig] : 1'b0;
        else res = (r.ntype == NT_SR);
      end
      NT_TON: if (n >= 1) begin
        a = work_sig[r.sg[0]];
        res = a & tmr_on[k];
        if (!a) begin
          tmr_on[k] = 1'b0;
          tmr_elapsed[k] = '0;
        end
      end
      NT_TOF: if (n >= 1) begin
        a = work_sig[r.sg[0]];
        if (a) begin
          res = 1'b1;
          tmr_on[k] = 1'b1;
        end else if (tmr_elapsed[k] >= r.preset) begin
          res = 1'b0;
          tmr_on[k] = 1'b0;
        end else res = tmr_on[k];
      end
      NT_CTU, NT_CTD: if (n >= 2) begin
        e = work_sig[r.sg[0]];
        ctl = work_sig[r.sg[1]];
        rise = e & !edge_mem[k];
        cv = {1'b0, ctr_val[k]};
        if (r.ntype == NT_CTU) begin
          if (ctl) cv = '0;
          else if (rise && cv < CNT_MAX) cv++;
          res = (cv >= r.preset);
        end else begin
          if (ctl) cv = {1'b0, r.preset};
          else if (rise && cv > 0) cv--;
          res = (cv == 0);
        end
        ctr_val[k] = cv[14:0];
        edge_mem[k] = e;
      end
      NT_BTN: res = (r.value != 0);
      default: ;
    endcase
    if (r.oen) work_sig[r.osig] = res;
    o.node_out = res;
    o.count_value = cv[14:0];
    return o;
  endfunction

  // checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      node_res_t got, want;
      got = '{out_node_out, out_count_value, out_scan_done};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected out=%0d cnt=%0d done=%0d, got out=%0d cnt=%0d done=%0d",
                     want.node_out, want.count_value, want.scan_done,
                     got.node_out, got.count_value, got.scan_done);
        end
      end
    end
  end

  task automatic send_request(req_t r);
    int gap;
    node_res_t pred;
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_cmd = r.cmd; in_node_type = r.ntype; in_instance_req = r.inst;
    in_in_count = r.cnt; in_sig_a = r.sg[0]; in_sig_b = r.sg[1];
    in_sig_c = r.sg[2]; in_sig_d = r.sg[3]; in_out_sig = r.osig;
    in_out_enable = r.oen; in_preset = r.preset; in_value = r.value;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = node_predict(r);
    expected_q.insert(expected_q.size(), pred);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic req_t rand_req(bit narrow);
    req_t r;
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) r.cmd = CMD_COMMIT;
    else if (p < 20) r.cmd = CMD_WRITE;
    else if (p < 35) r.cmd = CMD_TICK;
    else r.cmd = CMD_EVAL;
    r.ntype = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
    r.inst = narrow ? 6'($urandom_range(0, 3)) : 6'($urandom);
    r.cnt = 3'($urandom_range(0, 7));
    for (int i = 0; i < 4; i++) r.sg[i] = narrow ? 8'($urandom_range(0, 15)) : 8'($urandom);
    r.osig = narrow ? 8'($urandom_range(0, 15)) : 8'($urandom);
    r.oen = 1'($urandom);
    r.preset = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 6));
    r.value = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic req_t mk(logic [1:0] cmd, logic [3:0] t, logic [5:0] k,
                              logic [2:0] n, logic [7:0] a, logic [7:0] b,
                              logic [7:0] o, logic oen, logic [14:0] pv,
                              logic [15:0] v);
    req_t r;
    r.cmd = cmd; r.ntype = t; r.inst = k; r.cnt = n;
    r.sg[0] = a; r.sg[1] = b; r.sg[2] = 8'd255; r.sg[3] = 8'd0;
    r.osig = o; r.oen = oen; r.preset = pv; r.value = v;
    return r;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(mk(CMD_WRITE, NT_AND, 0, 0, 0, 0, 8'd1, 0, 0, 16'hFFFF));
    send_request(mk(CMD_WRITE, NT_AND, 0, 0, 0, 0, 8'd255, 0, 0, 16'h8000));
    send_request(mk(CMD_EVAL, NT_AND, 0, 0, 0, 0, 8'd2, 1, 0, 0));
    send_request(mk(CMD_EVAL, NT_AND, 63, 7, 1, 255, 8'd3, 1, 15'h7FFF, 0));
    send_request(mk(CMD_EVAL, NT_OR, 1, 2, 0, 1, 8'd4, 1, 0, 0));
    send_request(mk(CMD_EVAL, NT_XOR, 2, 4, 1, 2, 8'd5, 1, 0, 0));
    send_request(mk(CMD_EVAL, NT_NOT, 3, 1, 4, 0, 8'd6, 1, 0, 0));
    send_request(mk(CMD_EVAL, NT_EDGE, 4, 1, 1, 0, 8'd7, 1, 0, 0));
    send_request(mk(CMD_EVAL, NT_SR, 5, 1, 1, 255, 8'd8, 1, 0, 0));
    send_request(mk(CMD_EVAL, NT_RS, 6, 2, 1, 1, 8'd9, 1, 0, 0));
    send_request(mk(CMD_EVAL, NT_RS, 6, 2, 0, 0, 8'd9, 1, 0, 0));
    send_request(mk(CMD_COMMIT, NT_AND, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(CMD_EVAL, NT_TON, 7, 1, 1, 0, 8'd10, 1, 15'd3, 0));
    send_request(mk(CMD_TICK, NT_TON, 7, 1, 1, 0, 0, 0, 15'd3, 16'd2));
    send_request(mk(CMD_TICK, NT_TON, 7, 1, 1, 0, 0, 0, 15'd3, 16'hFFFF));
    send_request(mk(CMD_EVAL, NT_TOF, 8, 1, 1, 0, 8'd11, 1, 15'd5, 0));
    send_request(mk(CMD_TICK, NT_TOF, 8, 1, 0, 0, 0, 0, 15'd5, 16'd9));
    send_request(mk(CMD_TICK, NT_AND, 8, 1, 0, 0, 0, 0, 15'd5, 16'd9));
    send_request(mk(CMD_EVAL, NT_CTD, 9, 2, 1, 1, 8'd12, 1, 15'd2, 0));
    send_request(mk(CMD_EVAL, NT_CTD, 9, 2, 1, 0, 8'd12, 1, 15'd2, 0));
    send_request(mk(CMD_EVAL, NT_CTU, 10, 2, 1, 0, 8'd13, 1, 15'h7FFF, 0));
    send_request(mk(CMD_EVAL, NT_CTU, 10, 1, 1, 0, 8'd13, 1, 15'd1, 0));
    send_request(mk(CMD_EVAL, NT_BTN, 11, 0, 0, 0, 8'd14, 1, 0, 16'd1));
    send_request(mk(CMD_EVAL, 4'd15, 12, 0, 0, 0, 8'd15, 1, 0, 16'd1));
    send_request(mk(CMD_COMMIT, NT_AND, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random_scans(int n);
    for (int i = 0; i < n; i++) send_request(rand_req($urandom_range(0, 3) != 0));
  endtask

  task automatic test_saturation();
    req_t r;
    // evaluate an up counter (preset 5) twenty times, setting its count input high after each
    send_request(mk(CMD_WRITE, NT_AND, 0, 0, 0, 0, 8'd20, 0, 0, 0));
    send_request(mk(CMD_WRITE, NT_AND, 0, 0, 0, 0, 8'd21, 0, 0, 0));
    for (int i = 0; i < 20; i++) begin
      r = mk(CMD_EVAL, NT_CTU, 30, 2, 8'd20, 8'd21, 8'd20, 1, 15'd5, 0);
      send_request(r);
      send_request(mk(CMD_WRITE, NT_AND, 0, 0, 0, 0, 8'd20, 0, 0, 16'd1));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      live_sig[i] = 0;
      work_sig[i] = 0;
    end
    for (int i = 0; i < 64; i++) begin
      edge_mem[i] = 0; tmr_on[i] = 0; tmr_elapsed[i] = 0; ctr_val[i] = 0;
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_scans(450);
    wait_drained();
    test_saturation();
    test_random_scans(400);
    idle_gaps = 1'b0;
    test_random_scans(150);
    wait_drained();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
